// ----- rtl/mpa_pkg.sv -----
// ----------------------------------------------------------------------------
// mpa_pkg
// Shared constants and types for the power accumulator.
// ----------------------------------------------------------------------------
package mpa_pkg;

  localparam int RING_WRAP_DEF    = 21;
  localparam int SAMPLE_WIDTH_DEF = 24;

  localparam int SUM_W = 64;
  localparam int CNT_W = 32;

  // Interpolation weights, in 1/128 units
  localparam int WEIGHT_FAR   = 60;
  localparam int WEIGHT_NEAR  = 68;
  localparam int WEIGHT_SHIFT = 7;
  localparam int WEIGHT_W     = 8;

  // Stage controls handed to each multiply-accumulate lane
  typedef struct packed {
    logic load_prod;
    logic load_sum;
    logic restart;
  } mac_ctl_t;

endpackage

// ----- rtl/metering_power_accumulator.sv -----
// ----------------------------------------------------------------------------
// metering_power_accumulator
// Phase-shifted voltage and four running power sums per sample pair.
// ----------------------------------------------------------------------------
// Takes one voltage/current sample pair per cycle unless stalled, and returns
// one result per transaction through registered stages: interpolation of the
// quarter-period delay line, four parallel 24x24 multiplies, then the 64-bit
// accumulators, each stage one register deep with its own valid so bubbles
// fill while the output waits. The delay line is a chain of RING_WRAP-1
// sample cells cleared at reset; no clearing pass is needed. A set tuser bit
// restarts all sums with the current sample and sets the count to one.
module metering_power_accumulator #(
  parameter  int RING_WRAP    = mpa_pkg::RING_WRAP_DEF,
  parameter  int SAMPLE_WIDTH = mpa_pkg::SAMPLE_WIDTH_DEF,
  localparam int IN_W  = ((2 * SAMPLE_WIDTH + 7) / 8) * 8,
  localparam int OUT_W = ((4 * mpa_pkg::SUM_W + mpa_pkg::CNT_W + SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // voltage_sample, current_sample
  input  logic             in_tuser,   // mode
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // current_squared_sum, active_sum,
                                       // reactive_sum, voltage_squared_sum,
                                       // sample_total, shifted_voltage
);
  import mpa_pkg::*;

  localparam int SW = SAMPLE_WIDTH;

  logic signed [SW-1:0] in_v;
  logic signed [SW-1:0] in_i;
  logic signed [SW-1:0] shifted;
  logic                 load1;
  logic                 load2;
  logic                 load3;
  logic                 rdy2;
  logic                 rdy3;

  logic                 s1_vld_r;
  logic                 s1_restart_r;
  logic signed [SW-1:0] s1_v_r;
  logic signed [SW-1:0] s1_i_r;
  logic signed [SW-1:0] s1_q_r;
  logic                 s2_vld_r;
  logic                 s2_restart_r;
  logic signed [SW-1:0] s2_q_r;
  logic                 out_vld_r;
  logic [SW-1:0]        out_q_r;
  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     count_nxt;

  mac_ctl_t             ctl;
  logic [SUM_W-1:0]     sum_ii;
  logic [SUM_W-1:0]     sum_iv;
  logic [SUM_W-1:0]     sum_iq;
  logic [SUM_W-1:0]     sum_vv;

  assign in_v = in_tdata[SW-1:0];
  assign in_i = in_tdata[2*SW-1:SW];

  assign rdy3      = !out_vld_r || out_tready;
  assign rdy2      = !s2_vld_r || rdy3;
  assign in_tready = !s1_vld_r || rdy2;
  assign load1     = in_tvalid && in_tready;
  assign load2     = s1_vld_r && rdy2;
  assign load3     = s2_vld_r && rdy3;

  mpa_phase_shifter #(
    .RING_WRAP    (RING_WRAP),
    .SAMPLE_WIDTH (SW)
  ) u_shift (
    .clk       (clk),
    .rst_n     (rst_n),
    .shift_en  (load1),
    .sample_in (in_v),
    .shifted   (shifted)
  );

  // stage 1: interpolated voltage and the sample pair
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_tready) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (load1) begin
      s1_restart_r <= in_tuser;
      s1_v_r       <= in_v;
      s1_i_r       <= in_i;
      s1_q_r       <= shifted;
    end
  end

  // stage 2: products, held in the lanes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (rdy2) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load2) begin
      s2_restart_r <= s1_restart_r;
      s2_q_r       <= s1_q_r;
    end
  end

  assign ctl.load_prod = load2;
  assign ctl.load_sum  = load3;
  assign ctl.restart   = s2_restart_r;

  mpa_mac_lane #(.SAMPLE_WIDTH(SW)) u_lane_ii (
    .clk (clk), .rst_n (rst_n), .ctl (ctl),
    .op_a (s1_i_r), .op_b (s1_i_r), .sum (sum_ii)
  );

  mpa_mac_lane #(.SAMPLE_WIDTH(SW)) u_lane_iv (
    .clk (clk), .rst_n (rst_n), .ctl (ctl),
    .op_a (s1_i_r), .op_b (s1_v_r), .sum (sum_iv)
  );

  mpa_mac_lane #(.SAMPLE_WIDTH(SW)) u_lane_iq (
    .clk (clk), .rst_n (rst_n), .ctl (ctl),
    .op_a (s1_i_r), .op_b (s1_q_r), .sum (sum_iq)
  );

  mpa_mac_lane #(.SAMPLE_WIDTH(SW)) u_lane_vv (
    .clk (clk), .rst_n (rst_n), .ctl (ctl),
    .op_a (s1_v_r), .op_b (s1_v_r), .sum (sum_vv)
  );

  // stage 3: sums (in the lanes), count and the output register
  always_comb begin
    count_nxt = s2_restart_r ? CNT_W'(1) : count_r + CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      count_r   <= '0;
    end else begin
      if (rdy3) begin
        out_vld_r <= s2_vld_r;
      end
      if (load3) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load3) begin
      out_q_r <= s2_q_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_W'({out_q_r, count_r, sum_vv, sum_iq, sum_iv, sum_ii});

endmodule

// ----- rtl/mpa_tap_cell.sv -----
// ----------------------------------------------------------------------------
// mpa_tap_cell
// One sample of the delay line; loads its left neighbor on each shift.
// ----------------------------------------------------------------------------
module mpa_tap_cell #(
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           shift_en,
  input  logic signed [SAMPLE_WIDTH-1:0] tap_in,
  output logic signed [SAMPLE_WIDTH-1:0] tap_out
);

  logic signed [SAMPLE_WIDTH-1:0] tap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_r <= '0;
    end else if (shift_en) begin
      tap_r <= tap_in;
    end
  end

  assign tap_out = tap_r;

endmodule

// ----- rtl/mpa_phase_shifter.sv -----
// ----------------------------------------------------------------------------
// mpa_phase_shifter
// Quarter-period shifter: a chain of tap cells and a two-tap interpolator.
// ----------------------------------------------------------------------------
module mpa_phase_shifter #(
  parameter int RING_WRAP    = 21,
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           shift_en,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
  output logic signed [SAMPLE_WIDTH-1:0] shifted
);
  import mpa_pkg::*;

  localparam int NCELL = RING_WRAP - 1;
  localparam int PW    = SAMPLE_WIDTH + WEIGHT_W;
  localparam logic signed [PW-1:0] W_FAR  = PW'(WEIGHT_FAR);
  localparam logic signed [PW-1:0] W_NEAR = PW'(WEIGHT_NEAR);

  logic signed [SAMPLE_WIDTH-1:0] tap [NCELL+1];
  logic                           first_r;
  logic signed [PW-1:0]           far_ext;
  logic signed [PW-1:0]           near_ext;
  logic signed [PW-1:0]           prod_far;
  logic signed [PW-1:0]           prod_near;
  logic signed [PW-1:0]           sum_full;

  // The very first sample after reset enters the line as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 1'b1;
    end else if (shift_en) begin
      first_r <= 1'b0;
    end
  end

  assign tap[0] = first_r ? '0 : sample_in;

  // tap[k] holds the sample from k transactions ago
  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    mpa_tap_cell #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .tap_in   (tap[k]),
      .tap_out  (tap[k+1])
    );
  end

  assign far_ext   = {{WEIGHT_W{tap[NCELL-1][SAMPLE_WIDTH-1]}}, tap[NCELL-1]};
  assign near_ext  = {{WEIGHT_W{tap[NCELL][SAMPLE_WIDTH-1]}}, tap[NCELL]};
  assign prod_far  = far_ext * W_FAR;
  assign prod_near = near_ext * W_NEAR;
  // floor of each weighted term, then sum; result always fits the sample width
  assign sum_full  = (prod_far >>> WEIGHT_SHIFT) + (prod_near >>> WEIGHT_SHIFT);
  assign shifted   = sum_full[SAMPLE_WIDTH-1:0];

endmodule

// ----- rtl/mpa_mac_lane.sv -----
// ----------------------------------------------------------------------------
// mpa_mac_lane
// One multiply-accumulate lane: registered product, then 64-bit running sum.
// ----------------------------------------------------------------------------
module mpa_mac_lane #(
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  mpa_pkg::mac_ctl_t              ctl,
  input  logic signed [SAMPLE_WIDTH-1:0] op_a,
  input  logic signed [SAMPLE_WIDTH-1:0] op_b,
  output logic [mpa_pkg::SUM_W-1:0]      sum
);
  import mpa_pkg::*;

  localparam int PROD_W = 2 * SAMPLE_WIDTH;

  logic signed [PROD_W-1:0] prod;
  logic [SUM_W-1:0]         prod_r;
  logic [SUM_W-1:0]         sum_r;
  logic [SUM_W-1:0]         sum_nxt;

  assign prod = op_a * op_b;

  always_ff @(posedge clk) begin
    if (ctl.load_prod) begin
      prod_r <= {{(SUM_W-PROD_W){prod[PROD_W-1]}}, prod};
    end
  end

  always_comb begin
    sum_nxt = ctl.restart ? prod_r : sum_r + prod_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (ctl.load_sum) begin
      sum_r <= sum_nxt;
    end
  end

  assign sum = sum_r;

endmodule
